@@ rtl/ps2mct_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and movement decode for the PS/2 mouse cursor tracker.
package ps2mct_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int SIZE_BITS          = 13;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int QUEUE_DEPTH        = 2;
    localparam int MOVE_BITS          = 11;

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(640);
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(480);
    localparam int POS_X_RESET = 320;
    localparam int POS_Y_RESET = 240;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = CFG_INDEX_BITS'(1);

    localparam int HDR_BTN_LEFT   = 0;
    localparam int HDR_BTN_RIGHT  = 1;
    localparam int HDR_BTN_MIDDLE = 2;
    localparam int HDR_SYNC       = 3;
    localparam int HDR_X_SIGN     = 4;
    localparam int HDR_Y_SIGN     = 5;
    localparam int HDR_X_OVF      = 6;
    localparam int HDR_Y_OVF      = 7;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] move_x;
        logic [7:0] move_y;
    } packet_t;

    // A negative move is the byte minus 256, except that a zero byte stays zero.
    function automatic logic signed [MOVE_BITS-1:0] decode_move(
        input logic [7:0] b,
        input logic       neg,
        input logic       ovf
    );
        logic signed [MOVE_BITS-1:0] m;
        begin
            if (!neg)
            begin
                m = $signed({3'b000, b});
                if (ovf)
                begin
                    m = m + MOVE_BITS'(255);
                end
            end
            else
            begin
                if (b == 8'd0)
                begin
                    m = '0;
                end
                else
                begin
                    m = $signed({3'b111, b});
                end
                if (ovf)
                begin
                    m = m - MOVE_BITS'(255);
                end
            end
            return m;
        end
    endfunction

endpackage

@@ rtl/ps2mct_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces: received bytes, cursor results and configuration writes.
interface ps2mct_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ps2mct_cursor_if #(
    parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic                  button_left;
    logic                  button_right;
    logic                  button_middle;

    modport source (output valid, output cursor_x, output cursor_y, output button_left,
                    output button_right, output button_middle, input ready);
    modport sink (input valid, input cursor_x, input cursor_y, input button_left,
                  input button_right, input button_middle, output ready);
endinterface

interface ps2mct_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [ps2mct_pkg::CFG_INDEX_BITS-1:0] index;
    logic [ps2mct_pkg::SIZE_BITS-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/ps2mct_front.sv @@
`timescale 1ns / 1ps
// Front end: drops the first byte, synchronises on headers and assembles packets.
module ps2mct_front (
    input  logic                clk,
    input  logic                rst_n,
    ps2mct_byte_if.sink         rx,
    input  logic                queue_full,
    output logic                push,
    output ps2mct_pkg::packet_t push_packet
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_MOVE_X,
        PH_MOVE_Y
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic       skip_first_reg;
    logic [7:0] header_reg;
    logic [7:0] move_x_reg;
    logic       accept;

    assign rx.ready = !queue_full;
    assign accept   = rx.valid && !queue_full;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (rx.rx_byte[ps2mct_pkg::HDR_SYNC])
                begin
                    phase_next = PH_MOVE_X;
                end
            end
            PH_MOVE_X: phase_next = PH_MOVE_Y;
            PH_MOVE_Y: phase_next = PH_HEADER;
            default:   phase_next = PH_HEADER;
        endcase
    end

    assign push               = accept && !skip_first_reg && (phase_reg == PH_MOVE_Y);
    assign push_packet.header = header_reg;
    assign push_packet.move_x = move_x_reg;
    assign push_packet.move_y = rx.rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            skip_first_reg <= 1'b1;
            header_reg     <= '0;
            move_x_reg     <= '0;
        end
        else if (accept)
        begin
            if (skip_first_reg)
            begin
                skip_first_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                if (phase_reg == PH_HEADER && rx.rx_byte[ps2mct_pkg::HDR_SYNC])
                begin
                    header_reg <= rx.rx_byte;
                end
                if (phase_reg == PH_MOVE_X)
                begin
                    move_x_reg <= rx.rx_byte;
                end
            end
        end
    end

endmodule

@@ rtl/ps2mct_queue.sv @@
`timescale 1ns / 1ps
// Short packet queue between the front end and the position update.
module ps2mct_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ps2mct_pkg::packet_t push_packet,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output ps2mct_pkg::packet_t pop_packet
);

    localparam int PTR_BITS   = (ps2mct_pkg::QUEUE_DEPTH > 1) ? $clog2(ps2mct_pkg::QUEUE_DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(ps2mct_pkg::QUEUE_DEPTH + 1);

    ps2mct_pkg::packet_t   entry_reg [ps2mct_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [COUNT_BITS-1:0] count_reg;

    assign full       = (count_reg == COUNT_BITS'(ps2mct_pkg::QUEUE_DEPTH));
    assign not_empty  = (count_reg != '0);
    assign pop_packet = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
        begin
            if (p == PTR_BITS'(ps2mct_pkg::QUEUE_DEPTH - 1))
            begin
                return '0;
            end
            return p + PTR_BITS'(1);
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_packet;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= next_ptr(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= next_ptr(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - COUNT_BITS'(1);
            end
        end
    end

endmodule

@@ rtl/ps2mct_back.sv @@
`timescale 1ns / 1ps
// Back end: screen size registers, position update with clamping and the result register.
module ps2mct_back #(
    parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    ps2mct_cfg_if.sink          cfg,
    input  logic                queue_not_empty,
    input  ps2mct_pkg::packet_t queue_packet,
    output logic                pop,
    ps2mct_cursor_if.source     cursor
);

    localparam int SUM_BITS = COORD_BITS + 3;
    localparam int CMP_BITS = ((COORD_BITS > ps2mct_pkg::SIZE_BITS) ?
                               COORD_BITS : ps2mct_pkg::SIZE_BITS) + 1;
    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam logic [COORD_BITS-1:0] POS_X_INIT = COORD_BITS'(
        (ps2mct_pkg::POS_X_RESET > COORD_MAX) ? COORD_MAX : ps2mct_pkg::POS_X_RESET);
    localparam logic [COORD_BITS-1:0] POS_Y_INIT = COORD_BITS'(
        (ps2mct_pkg::POS_Y_RESET > COORD_MAX) ? COORD_MAX : ps2mct_pkg::POS_Y_RESET);

    logic [ps2mct_pkg::SIZE_BITS-1:0] width_reg;
    logic [ps2mct_pkg::SIZE_BITS-1:0] height_reg;
    logic [COORD_BITS-1:0]            pos_x_reg;
    logic [COORD_BITS-1:0]            pos_y_reg;
    logic [COORD_BITS-1:0]            pos_x_next;
    logic [COORD_BITS-1:0]            pos_y_next;
    logic                             out_valid_reg;
    logic [2:0]                       buttons_reg;

    logic signed [ps2mct_pkg::MOVE_BITS-1:0] move_x;
    logic signed [ps2mct_pkg::MOVE_BITS-1:0] move_y;
    logic signed [SUM_BITS-1:0]              sum_x;
    logic signed [SUM_BITS-1:0]              sum_y;

    // Largest coordinate for a size register; zero counts as one, and a size past the
    // coordinate range counts as the full range.
    function automatic logic [COORD_BITS-1:0] size_limit(
        input logic [ps2mct_pkg::SIZE_BITS-1:0] size
    );
        logic [CMP_BITS-1:0] size_ext;
        begin
            size_ext = CMP_BITS'(size);
            if (size == '0)
            begin
                return '0;
            end
            if (size_ext > (CMP_BITS'(1) << COORD_BITS))
            begin
                return '1;
            end
            return COORD_BITS'(size - ps2mct_pkg::SIZE_BITS'(1));
        end
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_pos(
        input logic signed [SUM_BITS-1:0] p,
        input logic [COORD_BITS-1:0]      lim
    );
        logic signed [SUM_BITS-1:0] lim_ext;
        begin
            lim_ext = $signed(SUM_BITS'(lim));
            if (p < 0)
            begin
                return '0;
            end
            if (p > lim_ext)
            begin
                return lim;
            end
            return p[COORD_BITS-1:0];
        end
    endfunction

    assign cfg.ready = 1'b1;
    assign pop       = queue_not_empty && (!out_valid_reg || cursor.ready);

    always_comb
    begin
        move_x = ps2mct_pkg::decode_move(queue_packet.move_x,
                                         queue_packet.header[ps2mct_pkg::HDR_X_SIGN],
                                         queue_packet.header[ps2mct_pkg::HDR_X_OVF]);
        move_y = ps2mct_pkg::decode_move(queue_packet.move_y,
                                         queue_packet.header[ps2mct_pkg::HDR_Y_SIGN],
                                         queue_packet.header[ps2mct_pkg::HDR_Y_OVF]);
        sum_x  = $signed(SUM_BITS'(pos_x_reg)) + SUM_BITS'(move_x);
        sum_y  = $signed(SUM_BITS'(pos_y_reg)) - SUM_BITS'(move_y);
        pos_x_next = clamp_pos(sum_x, size_limit(width_reg));
        pos_y_next = clamp_pos(sum_y, size_limit(height_reg));
    end

    assign cursor.valid         = out_valid_reg;
    assign cursor.cursor_x      = pos_x_reg;
    assign cursor.cursor_y      = pos_y_reg;
    assign cursor.button_left   = buttons_reg[0];
    assign cursor.button_right  = buttons_reg[1];
    assign cursor.button_middle = buttons_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= ps2mct_pkg::WIDTH_RESET;
            height_reg    <= ps2mct_pkg::HEIGHT_RESET;
            pos_x_reg     <= POS_X_INIT;
            pos_y_reg     <= POS_Y_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == ps2mct_pkg::CFG_SCREEN_WIDTH)
                begin
                    width_reg <= cfg.data;
                end
                else if (cfg.index == ps2mct_pkg::CFG_SCREEN_HEIGHT)
                begin
                    height_reg <= cfg.data;
                end
            end
            if (pop)
            begin
                pos_x_reg     <= pos_x_next;
                pos_y_reg     <= pos_y_next;
                out_valid_reg <= 1'b1;
            end
            else if (cursor.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            buttons_reg <= {queue_packet.header[ps2mct_pkg::HDR_BTN_MIDDLE],
                            queue_packet.header[ps2mct_pkg::HDR_BTN_RIGHT],
                            queue_packet.header[ps2mct_pkg::HDR_BTN_LEFT]};
        end
    end

endmodule

@@ rtl/ps2mct_top_doc.sv @@
`timescale 1ns / 1ps
// Top level of the PS/2 mouse cursor tracker.
//
// The rx channel takes one byte received from the mouse per transaction. The first
// byte after reset is dropped; after that, bytes form three-byte packets that start
// only on a header byte with bit 3 set, so a stray byte resynchronises the stream.
// The cursor channel delivers one transaction per complete packet: the clamped
// cursor position (zero at the top of the screen) and the three button bits.
// The cfg channel writes screen_width at index 0 and screen_height at index 1; it is
// always ready, other indexes are ignored, and writes belong to idle periods.
//
// A byte is accepted every cycle while the two-entry packet queue has room. The
// result of a packet enters the queue with its last byte and reaches the cursor
// channel through the output register; the back end's position update takes one
// packet per cycle while the receiver is ready. When the receiver stalls, the
// result stays in the output register, further packets wait in the queue, and rx
// ready falls only once the queue is full. Reset sets the screen to 640 by 480, the
// cursor to 320, 240 (limited to the coordinate range) and arms the first-byte drop.
module ps2_mouse_cursor_tracker_top #(
    parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    ps2mct_byte_if.sink     rx,
    ps2mct_cursor_if.source cursor,
    ps2mct_cfg_if.sink      cfg
);

    logic                queue_full;
    logic                queue_not_empty;
    logic                push;
    logic                pop;
    ps2mct_pkg::packet_t push_packet;
    ps2mct_pkg::packet_t pop_packet;

    ps2mct_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .queue_full  (queue_full),
        .push        (push),
        .push_packet (push_packet)
    );

    ps2mct_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_packet (push_packet),
        .full        (queue_full),
        .pop         (pop),
        .not_empty   (queue_not_empty),
        .pop_packet  (pop_packet)
    );

    ps2mct_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .queue_not_empty (queue_not_empty),
        .queue_packet    (pop_packet),
        .pop             (pop),
        .cursor          (cursor)
    );

endmodule

@@ tb/ps2mct_cursor_monitor.sv @@
`timescale 1ns / 1ps
// Cursor tracker scoreboard: predicts each packet's cursor result and checks the cursor channel.
module ps2mct_cursor_monitor
    import ps2mct_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rx_valid,
    input  logic                      rx_ready,
    input  logic [7:0]                rx_byte,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SIZE_BITS-1:0]      cfg_data,
    input  logic                      cursor_valid,
    input  logic                      cursor_ready,
    input  logic [COORD_BITS-1:0]     cursor_x,
    input  logic [COORD_BITS-1:0]     cursor_y,
    input  logic                      button_left,
    input  logic                      button_right,
    input  logic                      button_middle,
    output int                        waiting_results,
    output int                        mismatch_count
);

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_MOVE_X,
        PH_MOVE_Y
    } packet_phase_t;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  left;
        logic                  right;
        logic                  middle;
    } cursor_state_t;

    cursor_state_t        cursor_q[$];
    logic [SIZE_BITS-1:0] screen_w;
    logic [SIZE_BITS-1:0] screen_h;
    logic                 drop_next;
    packet_phase_t        phase;
    logic [7:0]           header;
    logic [7:0]           move_x;
    int                   pos_x;
    int                   pos_y;
    int                   fail_total;

    function automatic int move_amount(input logic [7:0] b, input logic neg, input logic ovf);
        int m;
        if (!neg)
            m = int'(b);
        else
            m = -((256 - int'(b)) % 256);
        if (ovf)
            m = neg ? m - 255 : m + 255;
        return m;
    endfunction

    function automatic int clamp_coord(input int p, input logic [SIZE_BITS-1:0] size);
        int lim;
        lim = int'(size) - 1;
        if (lim < 0)
            lim = 0;
        if (lim > COORD_MAX)
            lim = COORD_MAX;
        if (p < 0)
            p = 0;
        if (p > lim)
            p = lim;
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        fail_total++;
        $display("[%0t] cursor mismatch: %s", $time, what);
    endtask

    task automatic take_byte(input logic [7:0] b);
        cursor_state_t res;
        if (drop_next)
        begin
            drop_next = 1'b0;
        end
        else
        begin
            case (phase)
                PH_MOVE_X:
                begin
                    move_x = b;
                    phase  = PH_MOVE_Y;
                end
                PH_MOVE_Y:
                begin
                    pos_x = clamp_coord(pos_x + move_amount(move_x, header[HDR_X_SIGN],
                                                            header[HDR_X_OVF]), screen_w);
                    pos_y = clamp_coord(pos_y - move_amount(b, header[HDR_Y_SIGN],
                                                            header[HDR_Y_OVF]), screen_h);
                    res.x      = COORD_BITS'(pos_x);
                    res.y      = COORD_BITS'(pos_y);
                    res.left   = header[HDR_BTN_LEFT];
                    res.right  = header[HDR_BTN_RIGHT];
                    res.middle = header[HDR_BTN_MIDDLE];
                    cursor_q.push_back(res);
                    phase = PH_HEADER;
                end
                default:
                begin
                    phase = PH_HEADER;
                    if (b[HDR_SYNC])
                    begin
                        header = b;
                        phase  = PH_MOVE_X;
                    end
                end
            endcase
        end
    endtask

    task automatic check_cursor();
        cursor_state_t want;
        if (cursor_q.size() == 0)
        begin
            report_mismatch($sformatf("result x=%0d y=%0d with no packet outstanding",
                                      cursor_x, cursor_y));
        end
        else
        begin
            want = cursor_q.pop_front();
            if (cursor_x !== want.x || cursor_y !== want.y || button_left !== want.left ||
                button_right !== want.right || button_middle !== want.middle)
            begin
                report_mismatch($sformatf("got x=%0d y=%0d lrm=%b%b%b, want x=%0d y=%0d lrm=%b%b%b",
                                          cursor_x, cursor_y, button_left, button_right,
                                          button_middle, want.x, want.y, want.left,
                                          want.right, want.middle));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_q.delete();
            screen_w        = WIDTH_RESET;
            screen_h        = HEIGHT_RESET;
            drop_next       = 1'b1;
            phase           = PH_HEADER;
            header          = 8'd0;
            move_x          = 8'd0;
            pos_x           = (POS_X_RESET > COORD_MAX) ? COORD_MAX : POS_X_RESET;
            pos_y           = (POS_Y_RESET > COORD_MAX) ? COORD_MAX : POS_Y_RESET;
            fail_total      = 0;
            waiting_results <= 0;
            mismatch_count  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SCREEN_WIDTH)
                    screen_w = cfg_data;
                else if (cfg_index == CFG_SCREEN_HEIGHT)
                    screen_h = cfg_data;
            end
            if (cursor_valid && cursor_ready)
                check_cursor();
            if (rx_valid && rx_ready)
                take_byte(rx_byte);
            waiting_results <= cursor_q.size();
            mismatch_count  <= fail_total;
        end
    end

endmodule

@@ tb/ps2_mouse_cursor_tracker_top_tb.sv @@
`timescale 1ns / 1ps
// Top of the cursor tracker testbench: clock, reset, byte and configuration stimulus, verdict.
module ps2_mouse_cursor_tracker_top_tb;
    import ps2mct_pkg::*;

    localparam int COORD_BITS      = COORD_BITS_DEFAULT;
    localparam int PHASE_COUNT     = 6;
    localparam int PHASE_ITEMS     = 270;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_LO = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_HI = CFG_INDEX_BITS'(3);

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   src_gaps     = 1'b1;
    bit   sink_gaps    = 1'b1;
    int   hold_off_seq = 0;
    int   waiting_results;
    int   mismatch_count;

    ps2mct_byte_if                                rx_if ();
    ps2mct_cursor_if #(.COORD_BITS(COORD_BITS))   cur_if ();
    ps2mct_cfg_if                                 cfg_if ();

    ps2_mouse_cursor_tracker_top #(
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .cursor (cur_if),
        .cfg    (cfg_if)
    );

    ps2mct_cursor_monitor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx_if.valid),
        .rx_ready        (rx_if.ready),
        .rx_byte         (rx_if.rx_byte),
        .cfg_valid       (cfg_if.valid),
        .cfg_ready       (cfg_if.ready),
        .cfg_index       (cfg_if.index),
        .cfg_data        (cfg_if.data),
        .cursor_valid    (cur_if.valid),
        .cursor_ready    (cur_if.ready),
        .cursor_x        (cur_if.cursor_x),
        .cursor_y        (cur_if.cursor_y),
        .button_left     (cur_if.button_left),
        .button_right    (cur_if.button_right),
        .button_middle   (cur_if.button_middle),
        .waiting_results (waiting_results),
        .mismatch_count  (mismatch_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b);
        if (src_gaps && $urandom_range(99) < 8)
        begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx, input logic [7:0] dy);
        send_byte(hdr);
        send_byte(dx);
        send_byte(dy);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [SIZE_BITS-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (waiting_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : result_sink
        int seen_hold_off;
        seen_hold_off = 0;
        cur_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_off_seq != seen_hold_off)
            begin
                seen_hold_off = hold_off_seq;
                cur_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            cur_if.ready <= !(sink_gaps && $urandom_range(99) < 16);
            @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((rx_if.valid && rx_if.ready) || (cur_if.valid && cur_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int                   sent;
        logic [7:0]           hdr;
        logic [SIZE_BITS-1:0] w;
        logic [SIZE_BITS-1:0] h;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'd0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= CFG_SCREEN_WIDTH;
        cfg_if.data   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The first byte after reset is dropped even though it looks like a header.
        send_byte(8'h08);
        send_byte(8'h00);
        send_byte(8'hF7);
        send_packet(8'h0F, 8'h7F, 8'h7F);
        send_packet(8'h38, 8'h00, 8'h00);
        send_packet(8'h38, 8'h01, 8'h01);
        send_packet(8'hF8, 8'h80, 8'h80);
        send_packet(8'hC8, 8'hFF, 8'hFF);
        send_packet(8'h09, 8'hFF, 8'hFF);
        send_packet(8'h0C, 8'h05, 8'hFB);
        rx_if.valid <= 1'b0;
        wait_idle();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:
                begin
                    w = SIZE_BITS'(1);
                    h = SIZE_BITS'(4096);
                end
                1:
                begin
                    w = SIZE_BITS'(4096);
                    h = SIZE_BITS'(1);
                end
                2:
                begin
                    w = '0;
                    h = '1;
                end
                3:
                begin
                    w = '1;
                    h = '0;
                end
                4:
                begin
                    w = SIZE_BITS'($urandom_range(64, 1));
                    h = SIZE_BITS'($urandom_range(64, 1));
                end
                default:
                begin
                    w = SIZE_BITS'($urandom_range(4096, 1));
                    h = SIZE_BITS'($urandom_range(4096, 1));
                end
            endcase
            write_reg(CFG_SCREEN_WIDTH, w);
            write_reg((ph % 2) ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO, SIZE_BITS'($urandom()));
            write_reg(CFG_SCREEN_HEIGHT, h);
            cfg_if.valid <= 1'b0;

            src_gaps  = (ph != 1);
            sink_gaps <= (ph != 1);
            if (ph == 2)
                hold_off_seq <= hold_off_seq + 1;

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 12)
                begin
                    send_byte(8'($urandom()));
                    sent++;
                end
                else
                begin
                    hdr = 8'($urandom());
                    hdr[HDR_SYNC] = 1'b1;
                    if ($urandom_range(3) != 0)
                        hdr[HDR_X_OVF] = 1'b0;
                    if ($urandom_range(3) != 0)
                        hdr[HDR_Y_OVF] = 1'b0;
                    send_packet(hdr, 8'($urandom()), 8'($urandom()));
                    sent += 3;
                end
            end
            rx_if.valid <= 1'b0;
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
